[design/i2crs_pkg.sv]
// shared types and codes for the i2c register slave
`default_nettype none

package i2crs_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 4;

  // host action codes
  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  // bus phase codes
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_ADDR  = 3'd1;
  localparam logic [2:0] PH_PTR   = 3'd2;
  localparam logic [2:0] PH_WDATA = 3'd3;
  localparam logic [2:0] PH_RDATA = 3'd4;
  localparam logic [2:0] PH_MACK  = 3'd5;
  localparam logic [2:0] PH_ACK   = 3'd6;

  // configuration register indexes
  localparam logic CFG_OWN_ADDR = 1'b0;
  localparam logic CFG_ENABLE   = 1'b1;

  localparam logic [6:0] OWN_ADDR_RESET = 7'd8;
  localparam logic [7:0] READ_FILL      = 8'hFF;

  typedef struct packed {
    logic [1:0] action;
    logic       scl_level;
    logic       sda_level;
    logic [1:0] host_index;
    logic [7:0] host_data;
  } in_item_t;

  typedef struct packed {
    logic       sda_pull_low;
    logic       address_hit;
    logic       rx_valid;
    logic [1:0] rx_slot;
    logic [7:0] rx_byte;
    logic [7:0] host_read_data;
  } out_item_t;

endpackage

`default_nettype wire

[design/i2c_register_slave_core.sv]
// i2c register slave: one bus pin sample or host buffer access per transfer
//
// in_*  : one item per transfer; action selects a pin sample (scl/sda as
//         sampled this cycle), a host load of a transmit entry, or a host
//         read of a receive entry.
// out_* : exactly one result per input item, in order: sda drive, address
//         hit and receive strobes, and host read data.
// cfg_* : writes own address (index 0) and slave enable (index 1); always ready;
//         the user keeps it written only while the block is quiet (not enforced).
// The state update and result of an item are computed in the accept cycle and
// the result sits in the output register the cycle after. Throughput is one
// item per cycle while results are taken, set by the single pass of logic
// between the bus state registers and the output register.
// in_ready stays high while the output register is empty or being taken, so
// a stalled receiver holds the result and stops new items only when full.
// Reset: bus idle, pointer zero, lines seen as released, both buffers zero,
// own address 8 and slave disabled.
`default_nettype none

module i2c_register_slave_core
  import i2crs_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_index,
  input  wire logic [6:0] cfg_data
);

  // only the first four entries can ever be written by the host or read back
  localparam int STORE_DEPTH = (BUFFER_DEPTH < 4) ? BUFFER_DEPTH : 4;
  localparam int STORE_W     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [8:0] DEPTH_V = 9'(BUFFER_DEPTH);
  localparam logic [8:0] STORE_V = 9'(STORE_DEPTH);

  logic [6:0] own_addr_r;
  logic       enable_r;

  logic [2:0] phase_r, phase_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] ptr_r, ptr_nxt;
  logic       last_scl_r, last_scl_nxt;
  logic       last_sda_r, last_sda_nxt;
  logic       drive_r, drive_nxt;
  logic [7:0] tx_r [STORE_DEPTH];
  logic [7:0] tx_nxt [STORE_DEPTH];
  logic [7:0] rx_r [STORE_DEPTH];
  logic [7:0] rx_nxt [STORE_DEPTH];

  out_item_t out_r, out_nxt;
  logic      out_valid_r;
  logic      in_fire;

  logic       held_high, rising, falling;
  logic [7:0] tx_byte;
  logic [7:0] shifted;
  logic [8:0] ptr_inc;
  logic       idx_ok;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= OWN_ADDR_RESET;
      enable_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OWN_ADDR: own_addr_r <= cfg_data;
        CFG_ENABLE:   enable_r   <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    held_high = last_scl_r && in_data.scl_level;
    rising    = !last_scl_r && in_data.scl_level;
    falling   = last_scl_r && !in_data.scl_level;
    ptr_inc   = {1'b0, ptr_r} + 9'd1;
    shifted   = {shift_r[6:0], 1'b0};
    idx_ok    = {7'd0, in_data.host_index} < STORE_V;
    // byte sent on a read: stored entry, never-loaded entry, or past the end
    if ({1'b0, ptr_r} < STORE_V) begin
      tx_byte = tx_r[ptr_r[STORE_W-1:0]];
    end else if ({1'b0, ptr_r} < DEPTH_V) begin
      tx_byte = 8'd0;
    end else begin
      tx_byte = READ_FILL;
    end

    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    shift_nxt    = shift_r;
    ptr_nxt      = ptr_r;
    last_scl_nxt = last_scl_r;
    last_sda_nxt = last_sda_r;
    drive_nxt    = drive_r;
    tx_nxt       = tx_r;
    rx_nxt       = rx_r;
    out_nxt      = '0;

    case (in_data.action)
      ACT_LOAD: begin
        if (idx_ok) begin
          tx_nxt[in_data.host_index[STORE_W-1:0]] = in_data.host_data;
        end
      end
      ACT_READ: begin
        if (idx_ok) begin
          out_nxt.host_read_data = rx_r[in_data.host_index[STORE_W-1:0]];
        end
      end
      ACT_SAMPLE: begin
        if (held_high && last_sda_r && !in_data.sda_level) begin
          // start or repeated start
          if (enable_r) begin
            phase_nxt = PH_ADDR;
            cnt_nxt   = 4'd0;
            shift_nxt = 8'd0;
            drive_nxt = 1'b0;
          end
        end else if (held_high && !last_sda_r && in_data.sda_level) begin
          // stop
          phase_nxt = PH_IDLE;
          cnt_nxt   = 4'd0;
          drive_nxt = 1'b0;
        end else if (rising) begin
          case (phase_r)
            PH_ADDR, PH_PTR, PH_WDATA: begin
              if (cnt_r < 4'd8) begin
                shift_nxt = {shift_r[6:0], in_data.sda_level};
                cnt_nxt   = cnt_r + 4'd1;
              end
            end
            PH_RDATA: begin
              if (cnt_r < 4'd8) begin
                cnt_nxt = cnt_r + 4'd1;
              end
            end
            PH_MACK: begin
              // master nack ends the read
              if (in_data.sda_level) begin
                ptr_nxt   = 8'd0;
                phase_nxt = PH_IDLE;
                cnt_nxt   = 4'd0;
                drive_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end else if (falling) begin
          case (phase_r)
            PH_ADDR: begin
              if (cnt_r == 4'd8) begin
                if (shift_r[7:1] == own_addr_r) begin
                  out_nxt.address_hit = 1'b1;
                  phase_nxt = PH_ACK;
                  cnt_nxt   = shift_r[0] ? {1'b0, PH_RDATA} : {1'b0, PH_PTR};
                  drive_nxt = 1'b1;
                end else begin
                  phase_nxt = PH_IDLE;
                  cnt_nxt   = 4'd0;
                  drive_nxt = 1'b0;
                end
              end
            end
            PH_PTR: begin
              if (cnt_r == 4'd8) begin
                if ({1'b0, shift_r} < DEPTH_V) begin
                  ptr_nxt   = shift_r;
                  phase_nxt = PH_ACK;
                  cnt_nxt   = {1'b0, PH_WDATA};
                  drive_nxt = 1'b1;
                end else begin
                  phase_nxt = PH_IDLE;
                  cnt_nxt   = 4'd0;
                  drive_nxt = 1'b0;
                end
              end
            end
            PH_WDATA: begin
              if (cnt_r == 4'd8) begin
                if ({1'b0, ptr_r} < DEPTH_V) begin
                  if ({1'b0, ptr_r} < STORE_V) begin
                    rx_nxt[ptr_r[STORE_W-1:0]] = shift_r;
                  end
                  out_nxt.rx_valid = 1'b1;
                  out_nxt.rx_slot  = ptr_r[1:0];
                  out_nxt.rx_byte  = shift_r;
                  ptr_nxt          = ptr_inc[7:0];
                  if (ptr_inc < DEPTH_V) begin
                    phase_nxt = PH_ACK;
                    cnt_nxt   = {1'b0, PH_WDATA};
                    drive_nxt = 1'b1;
                  end else begin
                    // last slot is stored but not acked
                    phase_nxt = PH_IDLE;
                    cnt_nxt   = 4'd0;
                    drive_nxt = 1'b0;
                  end
                end else begin
                  phase_nxt = PH_IDLE;
                  cnt_nxt   = 4'd0;
                  drive_nxt = 1'b0;
                end
              end
            end
            PH_RDATA: begin
              if (cnt_r >= 4'd8) begin
                drive_nxt = 1'b0;
                cnt_nxt   = 4'd0;
                phase_nxt = PH_MACK;
              end else if (cnt_r != 4'd0) begin
                shift_nxt = shifted;
                drive_nxt = !shifted[7];
              end
            end
            PH_MACK: begin
              ptr_nxt   = ptr_inc[7:0];
              shift_nxt = tx_byte;
              cnt_nxt   = 4'd0;
              drive_nxt = !tx_byte[7];
              phase_nxt = PH_RDATA;
            end
            PH_ACK: begin
              drive_nxt = 1'b0;
              if (cnt_r == {1'b0, PH_RDATA}) begin
                ptr_nxt   = ptr_inc[7:0];
                shift_nxt = tx_byte;
                cnt_nxt   = 4'd0;
                drive_nxt = !tx_byte[7];
                phase_nxt = PH_RDATA;
              end else begin
                phase_nxt = (cnt_r == {1'b0, PH_PTR}) ? PH_PTR : PH_WDATA;
                cnt_nxt   = 4'd0;
                shift_nxt = 8'd0;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
              cnt_nxt   = 4'd0;
              drive_nxt = 1'b0;
            end
          endcase
        end
        last_scl_nxt = in_data.scl_level;
        last_sda_nxt = in_data.sda_level;
      end
      default: ;
    endcase

    out_nxt.sda_pull_low = drive_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= 4'd0;
      shift_r     <= 8'd0;
      ptr_r       <= 8'd0;
      last_scl_r  <= 1'b1;
      last_sda_r  <= 1'b1;
      drive_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        tx_r[i] <= 8'd0;
        rx_r[i] <= 8'd0;
      end
    end else begin
      if (in_fire) begin
        phase_r    <= phase_nxt;
        cnt_r      <= cnt_nxt;
        shift_r    <= shift_nxt;
        ptr_r      <= ptr_nxt;
        last_scl_r <= last_scl_nxt;
        last_sda_r <= last_sda_nxt;
        drive_r    <= drive_nxt;
        tx_r       <= tx_nxt;
        rx_r       <= rx_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

  // an address match always starts an ack
  a_hit_drives: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.address_hit |-> out_r.sda_pull_low)
    else $error("address hit without ack drive");

  // inside an ack the counter holds the phase that follows
  a_ack_next: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ACK |-> (cnt_r == {1'b0, PH_PTR} || cnt_r == {1'b0, PH_WDATA}
                           || cnt_r == {1'b0, PH_RDATA}))
    else $error("ack phase with bad follow-on phase");

  // host loads never move the bus state
  a_load_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.action == ACT_LOAD |=> phase_r == $past(phase_r))
    else $error("host load changed bus phase");

  // a disabled slave stays idle
  a_disabled_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !enable_r && phase_r == PH_IDLE |=> phase_r == PH_IDLE)
    else $error("disabled slave left idle");

endmodule

`default_nettype wire
